// ----- src/ccis_pkg.sv -----
// Shared types and constants for the cubic-convolution image sampler.
// No dependencies.
package ccis_pkg;

    localparam int WEIGHT_BITS = 14;
    localparam int OUT_FRAC    = 8;
    localparam int OUT_W       = 26;
    localparam int PIX_W       = 16;
    localparam int CFG_W       = 9;
    localparam int ACC_W       = 52;
    localparam int PROD_W      = 48;

    localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // One tap moving through the multiply/accumulate pipeline
    typedef struct packed {
        logic valid;
        logic in_range;
        logic first;
        logic last;
    } t_tap_ctl;

endpackage

// ----- src/ccis_ram.sv -----
// Generic single-port RAM with registered read and a read enable.
// No dependencies.
module ccis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_en,      // read register update
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/ccis_weight.sv -----
// Kernel weight (a = -1) for one distance, rounded to Q2.14; three register stages.
// Depends on ccis_pkg.
module ccis_weight #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS+1:0] i_dist,
    output logic signed [ccis_pkg::WEIGHT_BITS+2:0] o_weight
);
    localparam int TW  = FRAC_BITS + 2;
    localparam int NW  = 3 * FRAC_BITS + 6;
    localparam int SH  = 3 * FRAC_BITS - ccis_pkg::WEIGHT_BITS;
    localparam int OW  = ccis_pkg::WEIGHT_BITS + 3;
    localparam int NSH = (SH > 0) ? SH : 0;
    localparam int LSH = (SH < 0) ? -SH : 0;

    // stage 1: square
    logic [TW-1:0]     r_t1;
    logic [2*TW-1:0]   r_tt1;
    // stage 2: cube and squared term
    logic [TW-1:0]     r_t2;
    logic [2*TW-1:0]   r_tt2;
    logic [3*TW-1:0]   r_ttt2;
    // stage 3: polynomial and rounding
    logic signed [OW-1:0] r_w;
    logic signed [NW+4:0] n_num;
    logic signed [NW+4:0] s_f1, s_t, s_tt, s_ttt;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= i_dist;
            r_tt1  <= i_dist * i_dist;
            r_t2   <= r_t1;
            r_tt2  <= r_tt1;
            r_ttt2 <= r_tt1 * {{(2*TW-TW){1'b0}}, r_t1};
            r_w    <= OW'((n_num + ((SH > 0) ? ((NW+5)'(1) <<< (NSH - 1)) : '0))
                          >>> NSH) <<< LSH;
        end
    end

    always_comb begin
        s_f1  = (NW+5)'(1) <<< FRAC_BITS;
        s_t   = (NW+5)'(r_t2);
        s_tt  = (NW+5)'(r_tt2);
        s_ttt = (NW+5)'(r_ttt2);
        if (r_t2 < TW'(1 << FRAC_BITS)) begin
            n_num = (s_f1 <<< (2 * FRAC_BITS)) - ((s_tt <<< FRAC_BITS) <<< 1) + s_ttt;
        end else if (r_t2 < TW'(2 << FRAC_BITS)) begin
            n_num = ((s_f1 <<< (2 * FRAC_BITS)) <<< 2) - ((s_t <<< (2 * FRAC_BITS)) <<< 3)
                  + ((s_tt <<< FRAC_BITS) <<< 2) + (s_tt <<< FRAC_BITS) - s_ttt;
        end else begin
            n_num = '0;
        end
    end

    assign o_weight = r_w;
endmodule

// ----- src/cubic_convolution_image_sampler.sv -----
// Cubic-convolution image sampler: pixel store, weight pipelines, tap sequencer, MAC.
// Depends on ccis_pkg, ccis_ram, ccis_weight.
//
// A load transaction (mode 0) writes one pixel. A query transaction (mode 1)
// walks its 4x4 neighborhood one tap per cycle, while the output does not stall,
// through the single port of the pixel store, so the input is held off while the
// taps are walked and the next transaction is accepted once the last tap has been
// issued; its result is presented through a pipeline of weight, read, multiply and
// accumulate stages. The pixel store port is what sets the rate of a query. The
// next transaction is taken while a result waits at the output; a second finished
// result stalls the pipeline and the input until the first one is taken.
module cubic_convolution_image_sampler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] load_column, [15:8] load_row, [31:16] pixel_value,
    // [47:32] pos_x, [63:48] pos_y
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,     // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,     // [25:0] sample_value
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_wdata
);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int AW   = XW + YW;
    localparam int CW   = 17;             // signed tap coordinate
    localparam int WW   = ccis_pkg::WEIGHT_BITS + 3;
    localparam int DW   = FRAC_BITS + 2;
    localparam int WLAT = 3;
    localparam int RSH  = 2 * ccis_pkg::WEIGHT_BITS - ccis_pkg::OUT_FRAC;
    localparam int AC   = ccis_pkg::ACC_W;

    // ---------------- configuration
    logic [8:0] r_width, r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ccis_pkg::CFG_IDX_WIDTH:  r_width  <= i_cfg_wdata;
                ccis_pkg::CFG_IDX_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [12:0] s_wlim, s_hlim;
    assign s_wlim = (13'(r_width)  > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : 13'(r_width);
    assign s_hlim = (13'(r_height) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(r_height);

    // ---------------- input fields
    logic [7:0]  s_col, s_row;
    logic [15:0] s_pix, s_px, s_py;
    assign s_col = s_axis_tdata[7:0];
    assign s_row = s_axis_tdata[15:8];
    assign s_pix = s_axis_tdata[31:16];
    assign s_px  = s_axis_tdata[47:32];
    assign s_py  = s_axis_tdata[63:48];

    // ---------------- query sequencer
    logic        r_busy;
    logic [3:0]  r_tap;
    logic [15:0] r_px, r_py;
    logic        s_acc_in, s_load;
    logic        s_stall;

    assign s_axis_tready = !r_busy && !s_stall;
    assign s_acc_in = s_axis_tvalid && s_axis_tready;
    assign s_load   = s_acc_in && (s_axis_tuser == ccis_pkg::MODE_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tap  <= '0;
        end else if (!s_stall) begin
            if (s_acc_in && s_axis_tuser == ccis_pkg::MODE_QUERY) begin
                r_busy <= 1'b1;
                r_tap  <= '0;
                r_px   <= s_px;
                r_py   <= s_py;
            end else if (r_busy) begin
                r_tap <= r_tap + 4'd1;
                if (r_tap == 4'd15) r_busy <= 1'b0;
            end
        end
    end

    // tap address and distances, stage 0 combinational
    logic [1:0]         s_i, s_j;
    logic signed [CW-1:0] s_cx, s_cy;
    logic [FRAC_BITS-1:0] s_fx, s_fy;
    logic [DW-1:0]      s_dx, s_dy;
    logic               s_inr;

    function automatic logic [DW-1:0] dist_of(input logic [1:0] k,
                                              input logic [FRAC_BITS-1:0] fr);
        logic [DW-1:0] f1, f;
        begin
            f1 = DW'(1) << FRAC_BITS;
            f  = DW'(fr);
            case (k)
                2'd0:    dist_of = f1 + f;
                2'd1:    dist_of = f;
                2'd2:    dist_of = f1 - f;
                default: dist_of = (f1 << 1) - f;
            endcase
        end
    endfunction

    assign s_i  = r_tap[1:0];
    assign s_j  = r_tap[3:2];
    assign s_fx = r_px[FRAC_BITS-1:0];
    assign s_fy = r_py[FRAC_BITS-1:0];
    assign s_cx = CW'(r_px >> FRAC_BITS) + CW'(s_i) - CW'(1);
    assign s_cy = CW'(r_py >> FRAC_BITS) + CW'(s_j) - CW'(1);
    assign s_dx = dist_of(s_i, s_fx);
    assign s_dy = dist_of(s_j, s_fy);
    assign s_inr = (s_cx >= 0) && (s_cx < CW'(s_wlim)) && (s_cy >= 0) && (s_cy < CW'(s_hlim));

    // ---------------- pixel store
    logic [AW-1:0] s_addr;
    logic          s_we;
    logic [15:0]   s_rdata;
    logic          s_lok;
    assign s_lok  = (13'(s_col) < 13'(MAX_WIDTH)) && (13'(s_row) < 13'(MAX_HEIGHT));
    assign s_we   = s_load && s_lok;
    assign s_addr = s_load ? {YW'(s_row), XW'(s_col)}
                  : (s_inr ? {s_cy[YW-1:0], s_cx[XW-1:0]} : '0);

    // row and column fields side by side, so the store spans whole powers of two
    ccis_ram #(.WIDTH(ccis_pkg::PIX_W), .DEPTH(1 << AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_en   (!s_stall),
        .i_addr (s_addr),
        .i_wdata(s_pix),
        .o_rdata(s_rdata)
    );

    // ---------------- weights (3 stages), aligned with tap control
    logic signed [WW-1:0] s_wx, s_wy;
    ccis_weight #(.FRAC_BITS(FRAC_BITS)) u_wx (
        .i_clk(i_clk), .i_en(!s_stall), .i_dist(s_dx), .o_weight(s_wx));
    ccis_weight #(.FRAC_BITS(FRAC_BITS)) u_wy (
        .i_clk(i_clk), .i_en(!s_stall), .i_dist(s_dy), .o_weight(s_wy));

    ccis_pkg::t_tap_ctl s_c0;
    ccis_pkg::t_tap_ctl r_c [WLAT];
    logic [15:0] r_pix [WLAT-1];
    assign s_c0 = '{valid: r_busy, in_range: s_inr,
                    first: (r_tap == 4'd0), last: (r_tap == 4'd15)};

    // control delay; pixel read data lands after the first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WLAT; k++) r_c[k] <= '0;
        end else if (!s_stall) begin
            r_c[0] <= s_c0;
            for (int k = 1; k < WLAT; k++) r_c[k] <= r_c[k-1];
        end
    end

    // pixel read data, delayed to meet the weights
    always_ff @(posedge i_clk) begin
        if (!s_stall) begin
            r_pix[0] <= s_rdata;
            for (int k = 1; k < WLAT - 1; k++) r_pix[k] <= r_pix[k-1];
        end
    end

    // ---------------- multiply stages
    ccis_pkg::t_tap_ctl r_m1, r_m2;
    logic signed [2*WW-1:0] r_wxy;
    logic signed [15:0]     r_p1;
    logic signed [ccis_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1 <= '0;
            r_m2 <= '0;
        end else if (!s_stall) begin
            r_m1 <= r_c[WLAT-1];
            r_m2 <= r_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s_stall) begin
            r_wxy  <= s_wx * s_wy;
            r_p1   <= r_pix[WLAT-2];
            r_prod <= r_m1.in_range ? ccis_pkg::PROD_W'(r_wxy * r_p1) : '0;
        end
    end

    // ---------------- accumulate
    logic signed [AC-1:0] r_acc;
    logic                 r_done;
    logic signed [AC-1:0] s_sum;
    assign s_sum = (r_m2.first ? '0 : r_acc) + AC'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (!s_stall) begin
            r_done <= r_m2.valid && r_m2.last;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!s_stall && r_m2.valid) r_acc <= s_sum;
    end

    // ---------------- round, saturate, output register
    logic signed [AC-1:0] s_rnd;
    logic signed [ccis_pkg::OUT_W-1:0] s_sat;
    assign s_rnd = (r_acc + (AC'(1) <<< (RSH - 1))) >>> RSH;
    always_comb begin
        if (s_rnd > AC'(33554431))       s_sat = 26'sh1FFFFFF;
        else if (s_rnd < -AC'(33554432)) s_sat = 26'sh2000000;
        else                             s_sat = s_rnd[ccis_pkg::OUT_W-1:0];
    end

    logic        r_ovalid;
    logic [25:0] r_odata;
    assign s_stall = r_ovalid && !m_axis_tready && r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_done && !s_stall) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_done && !s_stall) r_odata <= s_sat;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odata};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready) else $error("accept while walking taps");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_we) else $error("store written during query");
`endif
endmodule
